// ----- rtl/tsb_pkg.sv -----
`default_nettype none

package tsb_pkg;

	// Fixed-point constants, signed Q32.32
	localparam logic [63:0] FX_ONE  = 64'h0000_0001_0000_0000;
	localparam logic [63:0] FX_ZERO = 64'h0;
	localparam logic [63:0] FX_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] FX_MIN  = 64'h8000_0000_0000_0000;

	// Configuration register reset values
	localparam logic [62:0] TIME_STEP_RST = 63'd4294967;
	localparam logic [32:0] THETA_RST     = 33'h0_8000_0000;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_TIME_STEP = 2'd0,
		CFG_THETA     = 2'd1,
		CFG_UPWIND    = 2'd2,
		CFG_BOUNDARY  = 2'd3
	} cfg_idx_t;

	// Point kinds
	localparam logic [1:0] KIND_FIRST = 2'd0;
	localparam logic [1:0] KIND_LAST  = 2'd2;

	typedef struct packed {
		logic [1:0]  position_kind;
		logic [63:0] drift;
		logic [63:0] diffusion;
		logic [63:0] reaction;
		logic [62:0] step_below;
		logic [62:0] step_above;
	} in_item_t;

	typedef struct packed {
		logic [63:0] impl_lower;
		logic [63:0] impl_diag;
		logic [63:0] impl_upper;
		logic [63:0] expl_lower;
		logic [63:0] expl_diag;
		logic [63:0] expl_upper;
		logic [63:0] lu_multiplier;
		logic [63:0] lu_pivot;
		logic        overflow;
	} out_item_t;

	typedef struct packed {
		logic [62:0] time_step;
		logic [32:0] theta_weight;
		logic        upwind_mode;
		logic [63:0] boundary_coeff;
	} cfg_t;

	typedef enum logic [2:0] {
		OP_ADD,
		OP_SUB,
		OP_ADDH,
		OP_MUL,
		OP_DIV
	} op_t;

	typedef struct packed {
		logic start;
		op_t  op;
	} alu_req_t;

	typedef struct packed {
		logic done;
		logic ovf;
	} alu_rsp_t;

	// Scratch registers of the sequencer
	typedef enum logic [4:0] {
		R_S, R_T, R_U, R_ALPHA, R_S2, R_K, R_LO, R_UP, R_MID, R_G,
		R_AA, R_BB, R_CC, R_A, R_B, R_C, R_A1, R_B1, R_C1, R_L, R_D
	} reg_t;

	localparam int NREG = 21;

	// Operand sources: scratch registers below 32, fixed values from 32 up
	typedef enum logic [5:0] {
		SRC_S     = 6'd0,
		SRC_T     = 6'd1,
		SRC_U     = 6'd2,
		SRC_ALPHA = 6'd3,
		SRC_S2    = 6'd4,
		SRC_K     = 6'd5,
		SRC_LO    = 6'd6,
		SRC_UP    = 6'd7,
		SRC_MID   = 6'd8,
		SRC_G     = 6'd9,
		SRC_AA    = 6'd10,
		SRC_BB    = 6'd11,
		SRC_CC    = 6'd12,
		SRC_A     = 6'd13,
		SRC_B     = 6'd14,
		SRC_L     = 6'd19,
		SRC_HU    = 6'd32,
		SRC_HD    = 6'd33,
		SRC_CX    = 6'd34,
		SRC_CXX   = 6'd35,
		SRC_C0    = 6'd36,
		SRC_DT    = 6'd37,
		SRC_TH    = 6'd38,
		SRC_OMT   = 6'd39,
		SRC_BC    = 6'd40,
		SRC_ONE   = 6'd41,
		SRC_ZERO  = 6'd42,
		SRC_PPIV  = 6'd43,
		SRC_PUP   = 6'd44,
		SRC_HSEL  = 6'd45,
		SRC_G1    = 6'd46,
		SRC_G2    = 6'd47
	} src_t;

	typedef enum logic [1:0] {
		CT_NEXT,
		CT_JUMP,
		CT_BRUP,
		CT_END
	} ctl_t;

	typedef struct packed {
		op_t        op;
		src_t       a;
		src_t       b;
		reg_t       dst;
		ctl_t       ctl;
		logic [5:0] nxt;
	} uinst_t;

	// Program entry points
	localparam logic [5:0] PC_INTERIOR = 6'd0;
	localparam logic [5:0] PC_UPWIND   = 6'd17;
	localparam logic [5:0] PC_TAIL     = 6'd22;
	localparam logic [5:0] PC_LU       = 6'd35;
	localparam logic [5:0] PC_FIRST    = 6'd38;
	localparam logic [5:0] PC_LAST     = 6'd46;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_ISSUE,
		ST_WAIT,
		ST_FIN
	} state_t;

	function automatic uinst_t mk(input op_t op, input src_t a, input src_t b,
			input reg_t dst, input ctl_t ctl, input logic [5:0] nxt);
		uinst_t u;
		u.op  = op;
		u.a   = a;
		u.b   = b;
		u.dst = dst;
		u.ctl = ctl;
		u.nxt = nxt;
		return u;
	endfunction

	// Microcode for one point
	function automatic uinst_t uc_rom(input logic [5:0] pc);
		uinst_t u;
		case (pc)
			// stencil geometry
			6'd0:  u = mk(OP_ADD,  SRC_HU,   SRC_HD,    R_S,     CT_NEXT, 6'd0);
			6'd1:  u = mk(OP_SUB,  SRC_HU,   SRC_HD,    R_T,     CT_NEXT, 6'd0);
			6'd2:  u = mk(OP_DIV,  SRC_T,    SRC_S,     R_ALPHA, CT_NEXT, 6'd0);
			6'd3:  u = mk(OP_MUL,  SRC_HU,   SRC_HU,    R_T,     CT_NEXT, 6'd0);
			6'd4:  u = mk(OP_MUL,  SRC_HD,   SRC_HD,    R_U,     CT_NEXT, 6'd0);
			6'd5:  u = mk(OP_ADDH, SRC_T,    SRC_U,     R_S2,    CT_NEXT, 6'd0);
			6'd6:  u = mk(OP_DIV,  SRC_CXX,  SRC_S2,    R_K,     CT_NEXT, 6'd0);
			6'd7:  u = mk(OP_ADD,  SRC_ONE,  SRC_ALPHA, R_T,     CT_NEXT, 6'd0);
			6'd8:  u = mk(OP_MUL,  SRC_K,    SRC_T,     R_LO,    CT_NEXT, 6'd0);
			6'd9:  u = mk(OP_SUB,  SRC_ONE,  SRC_ALPHA, R_T,     CT_NEXT, 6'd0);
			6'd10: u = mk(OP_MUL,  SRC_K,    SRC_T,     R_UP,    CT_NEXT, 6'd0);
			6'd11: u = mk(OP_ADD,  SRC_K,    SRC_K,     R_T,     CT_NEXT, 6'd0);
			6'd12: u = mk(OP_SUB,  SRC_C0,   SRC_T,     R_MID,   CT_BRUP, 6'd0);
			// central drift
			6'd13: u = mk(OP_DIV,  SRC_CX,   SRC_S,     R_G,     CT_NEXT, 6'd0);
			6'd14: u = mk(OP_SUB,  SRC_LO,   SRC_G,     R_AA,    CT_NEXT, 6'd0);
			6'd15: u = mk(OP_ADD,  SRC_MID,  SRC_ZERO,  R_BB,    CT_NEXT, 6'd0);
			6'd16: u = mk(OP_ADD,  SRC_UP,   SRC_G,     R_CC,    CT_JUMP, PC_TAIL);
			// upwind drift
			6'd17: u = mk(OP_DIV,  SRC_CX,   SRC_HSEL,  R_G,     CT_NEXT, 6'd0);
			6'd18: u = mk(OP_SUB,  SRC_LO,   SRC_G1,    R_AA,    CT_NEXT, 6'd0);
			6'd19: u = mk(OP_ADD,  SRC_MID,  SRC_G1,    R_T,     CT_NEXT, 6'd0);
			6'd20: u = mk(OP_SUB,  SRC_T,    SRC_G2,    R_BB,    CT_NEXT, 6'd0);
			6'd21: u = mk(OP_ADD,  SRC_UP,   SRC_G2,    R_CC,    CT_NEXT, 6'd0);
			// time step and theta weighting
			6'd22: u = mk(OP_MUL,  SRC_DT,   SRC_AA,    R_AA,    CT_NEXT, 6'd0);
			6'd23: u = mk(OP_MUL,  SRC_DT,   SRC_BB,    R_BB,    CT_NEXT, 6'd0);
			6'd24: u = mk(OP_MUL,  SRC_DT,   SRC_CC,    R_CC,    CT_NEXT, 6'd0);
			6'd25: u = mk(OP_MUL,  SRC_TH,   SRC_AA,    R_A,     CT_NEXT, 6'd0);
			6'd26: u = mk(OP_MUL,  SRC_TH,   SRC_BB,    R_T,     CT_NEXT, 6'd0);
			6'd27: u = mk(OP_ADD,  SRC_ONE,  SRC_T,     R_B,     CT_NEXT, 6'd0);
			6'd28: u = mk(OP_MUL,  SRC_TH,   SRC_CC,    R_C,     CT_NEXT, 6'd0);
			6'd29: u = mk(OP_MUL,  SRC_OMT,  SRC_AA,    R_T,     CT_NEXT, 6'd0);
			6'd30: u = mk(OP_SUB,  SRC_ZERO, SRC_T,     R_A1,    CT_NEXT, 6'd0);
			6'd31: u = mk(OP_MUL,  SRC_OMT,  SRC_BB,    R_T,     CT_NEXT, 6'd0);
			6'd32: u = mk(OP_SUB,  SRC_ONE,  SRC_T,     R_B1,    CT_NEXT, 6'd0);
			6'd33: u = mk(OP_MUL,  SRC_OMT,  SRC_CC,    R_T,     CT_NEXT, 6'd0);
			6'd34: u = mk(OP_SUB,  SRC_ZERO, SRC_T,     R_C1,    CT_NEXT, 6'd0);
			// Thomas recurrence
			6'd35: u = mk(OP_DIV,  SRC_A,    SRC_PPIV,  R_L,     CT_NEXT, 6'd0);
			6'd36: u = mk(OP_MUL,  SRC_L,    SRC_PUP,   R_T,     CT_NEXT, 6'd0);
			6'd37: u = mk(OP_SUB,  SRC_B,    SRC_T,     R_D,     CT_END,  6'd0);
			// first boundary row
			6'd38: u = mk(OP_ADD,  SRC_ZERO, SRC_ZERO,  R_A,     CT_NEXT, 6'd0);
			6'd39: u = mk(OP_ADD,  SRC_ONE,  SRC_ZERO,  R_B,     CT_NEXT, 6'd0);
			6'd40: u = mk(OP_SUB,  SRC_ZERO, SRC_BC,    R_C,     CT_NEXT, 6'd0);
			6'd41: u = mk(OP_ADD,  SRC_ZERO, SRC_ZERO,  R_A1,    CT_NEXT, 6'd0);
			6'd42: u = mk(OP_ADD,  SRC_ZERO, SRC_ZERO,  R_B1,    CT_NEXT, 6'd0);
			6'd43: u = mk(OP_ADD,  SRC_ZERO, SRC_ZERO,  R_C1,    CT_NEXT, 6'd0);
			6'd44: u = mk(OP_ADD,  SRC_ZERO, SRC_ZERO,  R_L,     CT_NEXT, 6'd0);
			6'd45: u = mk(OP_ADD,  SRC_ONE,  SRC_ZERO,  R_D,     CT_END,  6'd0);
			// last boundary row
			6'd46: u = mk(OP_SUB,  SRC_ZERO, SRC_BC,    R_A,     CT_NEXT, 6'd0);
			6'd47: u = mk(OP_ADD,  SRC_ONE,  SRC_ZERO,  R_B,     CT_NEXT, 6'd0);
			6'd48: u = mk(OP_ADD,  SRC_ZERO, SRC_ZERO,  R_C,     CT_NEXT, 6'd0);
			6'd49: u = mk(OP_ADD,  SRC_ZERO, SRC_ZERO,  R_A1,    CT_NEXT, 6'd0);
			6'd50: u = mk(OP_ADD,  SRC_ZERO, SRC_ZERO,  R_B1,    CT_NEXT, 6'd0);
			6'd51: u = mk(OP_ADD,  SRC_ZERO, SRC_ZERO,  R_C1,    CT_JUMP, PC_LU);
			default: u = mk(OP_ADD, SRC_ZERO, SRC_ZERO, R_T,     CT_END,  6'd0);
		endcase
		return u;
	endfunction

	// Signed value from a 128-bit magnitude, saturated; top bit is the overflow flag
	function automatic logic [64:0] sat_pack(input logic [63:0] hi, input logic [63:0] mag,
			input logic neg);
		logic        big;
		logic [63:0] v;
		big = (hi != 64'd0) || (neg ? (mag > FX_MIN) : (mag > FX_MAX));
		if (big) begin
			v = neg ? FX_MIN : FX_MAX;
		end else begin
			v = neg ? (~mag + 64'd1) : mag;
		end
		return {big, v};
	endfunction

	// Clamp a 65-bit signed sum to 64 bits; top bit is the overflow flag
	function automatic logic [64:0] sat_sum(input logic [64:0] s);
		if (s[64] != s[63]) begin
			return {1'b1, (s[64] ? FX_MIN : FX_MAX)};
		end
		return {1'b0, s[63:0]};
	endfunction

	function automatic logic [63:0] mag64(input logic [63:0] v);
		return v[63] ? (~v + 64'd1) : v;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/tsb_alu.sv -----
`default_nettype none

module tsb_alu (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire tsb_pkg::alu_req_t req,
	input  wire logic [63:0]      a,
	input  wire logic [63:0]      b,
	output tsb_pkg::alu_rsp_t     rsp,
	output logic [63:0]           y
);
	import tsb_pkg::*;

	logic         busy_q;
	op_t          op_q;
	logic [63:0]  a_q, b_q, ma_q, mb_q;
	logic         neg_q, divz_q;
	logic [7:0]   cnt_q;
	logic [63:0]  pp_q;
	logic [127:0] acc_q, nd_q, q_q;
	logic [63:0]  r_q;

	logic [64:0]  sum, dif, res;
	logic [31:0]  pa, pb;
	logic [127:0] acc_inc;
	logic [64:0]  rs;
	logic         ge;
	logic         done;

	// Operand latch and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 8'd0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= 8'd0;
		end else if (busy_q) begin
			if (done) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q + 8'd1;
		end
	end

	// Pick the partial product for this step
	always_comb begin
		case (cnt_q[1:0])
			2'd0: begin pa = ma_q[31:0];  pb = mb_q[31:0];  end
			2'd1: begin pa = ma_q[31:0];  pb = mb_q[63:32]; end
			2'd2: begin pa = ma_q[63:32]; pb = mb_q[31:0];  end
			default: begin pa = ma_q[63:32]; pb = mb_q[63:32]; end
		endcase
		case (cnt_q[2:0])
			3'd1: acc_inc = {64'd0, pp_q};
			3'd2, 3'd3: acc_inc = {32'd0, pp_q, 32'd0};
			3'd4: acc_inc = {pp_q, 64'd0};
			default: acc_inc = 128'd0;
		endcase
	end

	// Restoring divide step
	assign rs = {r_q, nd_q[127]};
	assign ge = rs >= {1'b0, mb_q};

	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q   <= req.op;
			a_q    <= a;
			b_q    <= b;
			ma_q   <= mag64(a);
			mb_q   <= mag64(b);
			neg_q  <= a[63] ^ b[63];
			divz_q <= (b == 64'd0);
			acc_q  <= 128'd0;
			nd_q   <= {32'd0, mag64(a), 32'd0};
			r_q    <= 64'd0;
			q_q    <= 128'd0;
		end else if (busy_q) begin
			if (op_q == OP_MUL) begin
				pp_q  <= pa * pb;
				acc_q <= acc_q + acc_inc;
			end
			if (op_q == OP_DIV && cnt_q[7] == 1'b0) begin
				r_q  <= ge ? 64'(rs - {1'b0, mb_q}) : rs[63:0];
				nd_q <= {nd_q[126:0], 1'b0};
				q_q  <= {q_q[126:0], ge};
			end
		end
	end

	assign sum = {a_q[63], a_q} + {b_q[63], b_q};
	assign dif = {a_q[63], a_q} - {b_q[63], b_q};

	// Finish and result
	always_comb begin
		done = 1'b0;
		res  = 65'd0;
		case (op_q)
			OP_ADD: begin
				done = busy_q;
				res  = sat_sum(sum);
			end
			OP_SUB: begin
				done = busy_q;
				res  = sat_sum(dif);
			end
			OP_ADDH: begin
				done = busy_q;
				res  = sat_sum(sum);
				res  = {res[64], res[63], res[63:1]};
			end
			OP_MUL: begin
				done = busy_q && (cnt_q == 8'd5);
				res  = sat_pack({32'd0, acc_q[127:96]}, acc_q[95:32], neg_q);
			end
			OP_DIV: begin
				if (divz_q) begin
					done = busy_q;
					if (ma_q == 64'd0) begin
						res = {1'b1, FX_ZERO};
					end else begin
						res = {1'b1, (a_q[63] ? FX_MIN : FX_MAX)};
					end
				end else begin
					done = busy_q && (cnt_q == 8'd128);
					res  = sat_pack(q_q[127:64], q_q[63:0], neg_q);
				end
			end
			default: begin
				done = busy_q;
				res  = 65'd0;
			end
		endcase
	end

	assign rsp.done = done;
	assign rsp.ovf  = res[64];
	assign y        = res[63:0];

endmodule

`default_nettype wire

// ----- rtl/tsb_seq.sv -----
`default_nettype none

module tsb_seq (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire tsb_pkg::in_item_t item,
	input  wire tsb_pkg::cfg_t     cfg,
	input  wire logic [63:0]       prev_pivot,
	input  wire logic [63:0]       prev_upper,
	input  wire logic              out_free,
	output logic                   ready,
	output logic                   fin,
	output tsb_pkg::out_item_t     result
);
	import tsb_pkg::*;

	state_t      state_q, state_d;
	logic [5:0]  pc_q, pc_next, pc_entry;
	in_item_t    item_q;
	uinst_t      ui;
	logic [63:0] rf [NREG];
	logic [63:0] rd_a_q, rd_b_q;
	logic [63:0] op_a, op_b, y;
	logic        ovf_q;
	out_item_t   res_q;
	alu_req_t    req;
	alu_rsp_t    rsp;
	logic        cx_pos;
	logic [63:0] omt;

	assign ui     = uc_rom(pc_q);
	assign cx_pos = !item_q.drift[63] && (item_q.drift != 64'd0);
	assign omt    = FX_ONE - {31'd0, cfg.theta_weight};

	// Register file address of a source
	function automatic reg_t rf_addr(input src_t s);
		if (s == SRC_G1 || s == SRC_G2) begin
			return R_G;
		end
		if (s[5]) begin
			return R_S;
		end
		return reg_t'(s[4:0]);
	endfunction

	function automatic logic [63:0] operand(input src_t s, input logic [63:0] rd);
		logic [63:0] v;
		case (s)
			SRC_HU:   v = {1'b0, item_q.step_above};
			SRC_HD:   v = {1'b0, item_q.step_below};
			SRC_CX:   v = item_q.drift;
			SRC_CXX:  v = item_q.diffusion;
			SRC_C0:   v = item_q.reaction;
			SRC_DT:   v = {1'b0, cfg.time_step};
			SRC_TH:   v = {31'd0, cfg.theta_weight};
			SRC_OMT:  v = omt;
			SRC_BC:   v = cfg.boundary_coeff;
			SRC_ONE:  v = FX_ONE;
			SRC_ZERO: v = FX_ZERO;
			SRC_PPIV: v = prev_pivot;
			SRC_PUP:  v = prev_upper;
			SRC_HSEL: v = cx_pos ? {1'b0, item_q.step_above} : {1'b0, item_q.step_below};
			SRC_G1:   v = cx_pos ? FX_ZERO : rd;
			SRC_G2:   v = cx_pos ? rd : FX_ZERO;
			default:  v = rd;
		endcase
		return v;
	endfunction

	assign op_a = operand(ui.a, rd_a_q);
	assign op_b = operand(ui.b, rd_b_q);

	assign req.start = (state_q == ST_ISSUE);
	assign req.op    = ui.op;

	tsb_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.a      (op_a),
		.b      (op_b),
		.rsp    (rsp),
		.y      (y)
	);

	// Program entry by point kind and next program counter
	always_comb begin
		case (item.position_kind)
			KIND_FIRST: pc_entry = PC_FIRST;
			KIND_LAST:  pc_entry = PC_LAST;
			default:    pc_entry = PC_INTERIOR;
		endcase
		case (ui.ctl)
			CT_JUMP: pc_next = ui.nxt;
			CT_BRUP: pc_next = cfg.upwind_mode ? PC_UPWIND : 6'(pc_q + 6'd1);
			default: pc_next = 6'(pc_q + 6'd1);
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q    <= PC_INTERIOR;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start) begin
				pc_q  <= pc_entry;
				ovf_q <= 1'b0;
			end else if (state_q == ST_WAIT && rsp.done) begin
				pc_q  <= pc_next;
				ovf_q <= ovf_q | rsp.ovf;
			end
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		ready   = 1'b0;
		fin     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				ready = 1'b1;
				if (start) begin
					state_d = ST_FETCH;
				end
			end
			ST_FETCH: state_d = ST_ISSUE;
			ST_ISSUE: state_d = ST_WAIT;
			ST_WAIT: begin
				if (rsp.done) begin
					state_d = (ui.ctl == CT_END) ? ST_FIN : ST_FETCH;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					fin     = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Register file, operand read and result capture
	always_ff @(posedge clk) begin
		if (start) begin
			item_q <= item;
		end
		if (state_q == ST_FETCH) begin
			rd_a_q <= rf[rf_addr(ui.a)];
			rd_b_q <= rf[rf_addr(ui.b)];
		end
		if (state_q == ST_WAIT && rsp.done) begin
			rf[ui.dst]     <= y;
			res_q.overflow <= ovf_q | rsp.ovf;
			case (ui.dst)
				R_A:  res_q.impl_lower    <= y;
				R_B:  res_q.impl_diag     <= y;
				R_C:  res_q.impl_upper    <= y;
				R_A1: res_q.expl_lower    <= y;
				R_B1: res_q.expl_diag     <= y;
				R_C1: res_q.expl_upper    <= y;
				R_L:  res_q.lu_multiplier <= y;
				R_D:  res_q.lu_pivot      <= y;
				default: ;
			endcase
		end
	end

	assign result = res_q;

endmodule

`default_nettype wire

// ----- rtl/theta_scheme_tridiag_builder_core.sv -----
`default_nettype none

// Theta-scheme tridiagonal row builder with Thomas factorization.
// Feed the points of one grid line in order on in_item (valid/stall); a
// first-point item restarts the LU recurrence. One result item per input
// item comes out on out_item (valid/stall) with the implicit and explicit
// rows, the Thomas multiplier and pivot, and an overflow flag.
// Each item runs a microcode program on one shared arithmetic unit; an
// interior point runs four divides, a last point one and a first point
// none (a zero divisor skips the bit loop). The restoring divider, one
// quotient bit a cycle over 128 bits, sets the pace of every point that
// divides. in_stall is high while an item is in work. A finished result
// waits in the output register; while it is stalled, the next item is
// still taken and computed, and only its hand-off waits. Reset clears the
// recurrence state, the registers to their defaults and the output valid.
// Write configuration through the APB port only while
// idle.
module theta_scheme_tridiag_builder_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [4:0]         paddr,
	input  wire logic [63:0]        pwdata,
	output logic [63:0]             prdata,
	output logic                    pready,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire tsb_pkg::in_item_t  in_item,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output tsb_pkg::out_item_t      out_item
);
	import tsb_pkg::*;

	cfg_t        cfg_q;
	logic [63:0] prev_pivot_q, prev_upper_q;
	logic        out_valid_q;
	out_item_t   out_q;
	logic        ready, fin, start, out_free, wr;
	out_item_t   result;

	assign pready   = 1'b1;
	assign wr       = psel && penable && pwrite;
	assign start    = in_valid && ready;
	assign in_stall = !ready;
	assign out_free = !out_valid_q || !out_stall;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.time_step      <= TIME_STEP_RST;
			cfg_q.theta_weight   <= THETA_RST;
			cfg_q.upwind_mode    <= 1'b0;
			cfg_q.boundary_coeff <= FX_ZERO;
		end else if (wr) begin
			case (cfg_idx_t'(paddr[4:3]))
				CFG_TIME_STEP: cfg_q.time_step      <= pwdata[62:0];
				CFG_THETA:     cfg_q.theta_weight   <= pwdata[32:0];
				CFG_UPWIND:    cfg_q.upwind_mode    <= pwdata[0];
				CFG_BOUNDARY:  cfg_q.boundary_coeff <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx_t'(paddr[4:3]))
			CFG_TIME_STEP: prdata = {1'b0, cfg_q.time_step};
			CFG_THETA:     prdata = {31'd0, cfg_q.theta_weight};
			CFG_UPWIND:    prdata = {63'd0, cfg_q.upwind_mode};
			CFG_BOUNDARY:  prdata = cfg_q.boundary_coeff;
			default:       prdata = 64'd0;
		endcase
	end

	tsb_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.item       (in_item),
		.cfg        (cfg_q),
		.prev_pivot (prev_pivot_q),
		.prev_upper (prev_upper_q),
		.out_free   (out_free),
		.ready      (ready),
		.fin        (fin),
		.result     (result)
	);

	// Advance the recurrence and hold the result for the receiver
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_pivot_q <= FX_ZERO;
			prev_upper_q <= FX_ZERO;
			out_valid_q  <= 1'b0;
		end else begin
			if (fin) begin
				prev_pivot_q <= result.lu_pivot;
				prev_upper_q <= result.impl_upper;
				out_valid_q  <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

`default_nettype wire

// ----- tb/tb_theta_scheme_tridiag_builder_core.sv -----
`default_nettype none

module tb_theta_scheme_tridiag_builder_core;
	import tsb_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam longint ONE_FX = 64'sh0000_0001_0000_0000;
	localparam longint MAX_FX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam longint MIN_FX = 64'sh8000_0000_0000_0000;
	localparam int     CYCLE_LIMIT = 8000000;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_stall;
	in_item_t    in_item;
	logic        out_valid;
	logic        out_stall;
	out_item_t   out_item;

	theta_scheme_tridiag_builder_core u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
	);

	// Predictor copy of the registers and recurrence state
	logic [62:0]  dt_reg;
	logic [32:0]  theta_reg;
	logic         upwind_reg;
	logic [63:0]  bc_reg;
	longint       last_pivot;
	longint       last_upper;
	bit           sat_flag;

	in_item_t     point_queue[$];
	out_item_t    row_queue[$];
	int           errors;
	int           cycles;
	int           gap_left;
	int           stall_left;
	bit           hold_input;

	always #1 clk = ~clk;

	// Signed value from a 128-bit magnitude, clamped
	function automatic longint clamp128(input logic [127:0] mag, input bit neg);
		if (neg) begin
			if (mag > 128'h8000_0000_0000_0000) begin
				sat_flag = 1;
				return MIN_FX;
			end
			return -longint'(mag[63:0]);
		end
		if (mag > 128'h7FFF_FFFF_FFFF_FFFF) begin
			sat_flag = 1;
			return MAX_FX;
		end
		return longint'(mag[63:0]);
	endfunction

	function automatic logic [127:0] abs64(input longint v);
		logic [63:0] u;
		u = v;
		return {64'd0, (v < 0) ? (~u + 64'd1) : u};
	endfunction

	function automatic longint q_add(input longint a, input longint b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s > 65'sd9223372036854775807) begin
			sat_flag = 1;
			return MAX_FX;
		end
		if (s < -65'sd9223372036854775808) begin
			sat_flag = 1;
			return MIN_FX;
		end
		return longint'(s);
	endfunction

	function automatic longint q_sub(input longint a, input longint b);
		logic signed [64:0] s;
		s = 65'(a) - 65'(b);
		if (s > 65'sd9223372036854775807) begin
			sat_flag = 1;
			return MAX_FX;
		end
		if (s < -65'sd9223372036854775808) begin
			sat_flag = 1;
			return MIN_FX;
		end
		return longint'(s);
	endfunction

	function automatic longint q_mul(input longint a, input longint b);
		logic [127:0] p;
		p = abs64(a) * abs64(b);
		return clamp128(p >> 32, (a < 0) != (b < 0));
	endfunction

	function automatic longint q_div(input longint a, input longint b);
		logic [127:0] q;
		if (b == 0) begin
			sat_flag = 1;
			if (a == 0)
				return 0;
			return (a < 0) ? MIN_FX : MAX_FX;
		end
		q = (abs64(a) << 32) / abs64(b);
		return clamp128(q, (a < 0) != (b < 0));
	endfunction

	// Build the expected row for one grid point and advance the recurrence
	function automatic out_item_t build_row(input in_item_t p);
		out_item_t r;
		longint cx, cxx, c0, hd, hu, th, dt, omt;
		longint a, b, c, a1, b1, c1, l, d;
		longint s, alpha, s2, k, lo_part, up_part, mid, aa, bb, cc, g, g1, g2;
		cx = p.drift;
		cxx = p.diffusion;
		c0 = p.reaction;
		hd = {1'b0, p.step_below};
		hu = {1'b0, p.step_above};
		th = {31'd0, theta_reg};
		dt = {1'b0, dt_reg};
		a = 0; b = ONE_FX; c = 0; a1 = 0; b1 = 0; c1 = 0; l = 0;
		sat_flag = 0;
		if (p.position_kind == KIND_FIRST) begin
			c = q_sub(0, bc_reg);
		end else if (p.position_kind == KIND_LAST) begin
			a = q_sub(0, bc_reg);
		end else begin
			s = q_add(hu, hd);
			alpha = q_div(q_sub(hu, hd), s);
			s2 = q_add(q_mul(hu, hu), q_mul(hd, hd)) >>> 1;
			k = q_div(cxx, s2);
			lo_part = q_mul(k, q_add(ONE_FX, alpha));
			up_part = q_mul(k, q_sub(ONE_FX, alpha));
			mid = q_sub(c0, q_add(k, k));
			if (upwind_reg) begin
				g1 = 0;
				g2 = 0;
				if (cx > 0)
					g2 = q_div(cx, hu);
				else
					g1 = q_div(cx, hd);
				aa = q_sub(lo_part, g1);
				bb = q_sub(q_add(mid, g1), g2);
				cc = q_add(up_part, g2);
			end else begin
				g = q_div(cx, s);
				aa = q_sub(lo_part, g);
				bb = mid;
				cc = q_add(up_part, g);
			end
			aa = q_mul(dt, aa);
			bb = q_mul(dt, bb);
			cc = q_mul(dt, cc);
			omt = ONE_FX - th;
			a = q_mul(th, aa);
			b = q_add(ONE_FX, q_mul(th, bb));
			c = q_mul(th, cc);
			a1 = q_sub(0, q_mul(omt, aa));
			b1 = q_sub(ONE_FX, q_mul(omt, bb));
			c1 = q_sub(0, q_mul(omt, cc));
		end
		if (p.position_kind == KIND_FIRST) begin
			d = b;
		end else begin
			l = q_div(a, last_pivot);
			d = q_sub(b, q_mul(l, last_upper));
		end
		last_pivot = d;
		last_upper = c;
		r.impl_lower = a;
		r.impl_diag = b;
		r.impl_upper = c;
		r.expl_lower = a1;
		r.expl_diag = b1;
		r.expl_upper = c1;
		r.lu_multiplier = l;
		r.lu_pivot = d;
		r.overflow = sat_flag;
		return r;
	endfunction

	function automatic int pick_gap();
		int n;
		n = $urandom_range(0, 99);
		if (n < 45)
			return 0;
		if (n < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic logic [62:0] rand_step();
		case ($urandom_range(0, 5))
			0: return 63'd0;
			1: return 63'({$urandom, $urandom});
			2: return 63'h7FFF_FFFF_FFFF_FFFF;
			default: return 63'({$urandom_range(0, 3), $urandom});
		endcase
	endfunction

	function automatic logic [63:0] rand_coeff();
		logic [63:0] v;
		case ($urandom_range(0, 5))
			0: v = {$urandom, $urandom};
			1: v = 64'd0;
			default: begin
				v = 64'({$urandom_range(0, 255), $urandom});
				if ($urandom_range(0, 1))
					v = ~v + 64'd1;
			end
		endcase
		return v;
	endfunction

	function automatic in_item_t rand_point(input logic [1:0] kind);
		in_item_t p;
		p.position_kind = kind;
		p.drift = rand_coeff();
		p.diffusion = rand_coeff();
		p.reaction = rand_coeff();
		p.step_below = rand_step();
		p.step_above = rand_step();
		return p;
	endfunction

	// Driver: present the pending items with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_item <= '0;
			gap_left <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				row_queue.push_back(build_row(in_item));
				if (point_queue.size() > 0 && !hold_input && pick_gap() == 0) begin
					in_item <= point_queue.pop_front();
				end else begin
					in_valid <= 1'b0;
					gap_left <= pick_gap();
				end
			end else if (!in_valid) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
				end else if (point_queue.size() > 0 && !hold_input) begin
					in_valid <= 1'b1;
					in_item <= point_queue.pop_front();
				end
			end
		end
	end

	// Monitor: stall at random and compare each row
	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (row_queue.size() == 0) begin
					$display("%0t: unexpected row %h", $realtime, out_item);
					errors++;
				end else begin
					want = row_queue.pop_front();
					if (out_item !== want) begin
						$display("%0t: row mismatch expected %h actual %h",
							$realtime, want, out_item);
						errors++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_stall <= 1'b1;
			end else begin
				stall_left <= pick_gap();
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic apb_write(input cfg_idx_t idx, input logic [63:0] value);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= 5'(idx) * 5'd8;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			CFG_TIME_STEP: dt_reg = value[62:0];
			CFG_THETA:     theta_reg = value[32:0];
			CFG_UPWIND:    upwind_reg = value[0];
			default:       bc_reg = value;
		endcase
	endtask

	task automatic wait_drained();
		while (point_queue.size() > 0 || in_valid || row_queue.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Queue one grid line with the given number of interior points
	task automatic queue_line(input int interior);
		point_queue.push_back(rand_point(KIND_FIRST));
		repeat (interior)
			point_queue.push_back(rand_point($urandom_range(0, 7) == 0 ? 2'd3 : 2'd1));
		point_queue.push_back(rand_point(KIND_LAST));
	endtask

	initial begin
		in_item_t p;
		int queued;
		clk = 0;
		arst_n = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		errors = 0;
		cycles = 0;
		hold_input = 0;
		dt_reg = TIME_STEP_RST;
		theta_reg = THETA_RST;
		upwind_reg = 0;
		bc_reg = '0;
		last_pivot = 0;
		last_upper = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Interior point straight out of reset divides by the cleared pivot
		p = rand_point(2'd1);
		p.step_below = 63'h1_0000_0000;
		p.step_above = 63'h2_0000_0000;
		point_queue.push_back(p);
		// Line with extremes of every field
		p = rand_point(KIND_FIRST);
		point_queue.push_back(p);
		p.position_kind = 2'd1;
		p.drift = 64'h7FFF_FFFF_FFFF_FFFF;
		p.diffusion = 64'h8000_0000_0000_0000;
		p.reaction = 64'h7FFF_FFFF_FFFF_FFFF;
		p.step_below = 63'h7FFF_FFFF_FFFF_FFFF;
		p.step_above = 63'h7FFF_FFFF_FFFF_FFFF;
		point_queue.push_back(p);
		p.drift = 64'h8000_0000_0000_0000;
		p.diffusion = 64'h7FFF_FFFF_FFFF_FFFF;
		p.reaction = 64'h8000_0000_0000_0000;
		p.step_below = 63'd0;
		p.step_above = 63'd0;
		point_queue.push_back(p);
		p.position_kind = 2'd3;
		p.drift = 0;
		p.diffusion = 0;
		p.reaction = 0;
		point_queue.push_back(p);
		p.position_kind = 2'd1;
		p.drift = 64'h0000_0002_0000_0000;
		p.diffusion = 64'h0000_0000_8000_0000;
		p.step_below = 63'h1_0000_0000;
		p.step_above = 63'h0_8000_0000;
		point_queue.push_back(p);
		p.position_kind = KIND_LAST;
		point_queue.push_back(p);
		wait_drained();

		// Upwind, full theta, large time step, negative boundary coefficient
		apb_write(CFG_UPWIND, 64'd1);
		apb_write(CFG_THETA, 64'h1_0000_0000);
		apb_write(CFG_TIME_STEP, 64'h7FFF_FFFF_FFFF_FFFF);
		apb_write(CFG_BOUNDARY, 64'h8000_0000_0000_0000);
		p.position_kind = KIND_FIRST;
		point_queue.push_back(p);
		p.position_kind = 2'd1;
		p.drift = 64'h0000_0001_0000_0000;
		point_queue.push_back(p);
		p.drift = 64'hFFFF_FFFF_0000_0000;
		point_queue.push_back(p);
		p.drift = 0;
		p.step_below = 0;
		point_queue.push_back(p);
		p.position_kind = KIND_LAST;
		point_queue.push_back(p);
		wait_drained();

		// Random lines under several settings, most lines short
		queued = 0;
		while (queued < 1600) begin
			if ($urandom_range(0, 3) == 0) begin
				wait_drained();
				apb_write(CFG_UPWIND, 64'($urandom_range(0, 1)));
				case ($urandom_range(0, 3))
					0: apb_write(CFG_THETA, 64'd0);
					1: apb_write(CFG_THETA, 64'h1_FFFF_FFFF);
					default: apb_write(CFG_THETA,
						{31'd0, 1'($urandom_range(0, 1)), $urandom});
				endcase
				case ($urandom_range(0, 3))
					0: apb_write(CFG_TIME_STEP, 64'd0);
					1: apb_write(CFG_TIME_STEP, {1'b0, 63'({$urandom, $urandom})});
					default: apb_write(CFG_TIME_STEP, 64'($urandom_range(0, 1 << 20)));
				endcase
				case ($urandom_range(0, 3))
					0: apb_write(CFG_BOUNDARY, 64'h7FFF_FFFF_FFFF_FFFF);
					1: apb_write(CFG_BOUNDARY, {$urandom, $urandom});
					default: apb_write(CFG_BOUNDARY, rand_coeff());
				endcase
			end
			if ($urandom_range(0, 9) == 0) begin
				// Stray points outside a proper line
				point_queue.push_back(rand_point(2'($urandom_range(0, 3))));
				queued++;
			end else begin
				p.position_kind = 2'($urandom_range(1, 8));
				queue_line(p.position_kind);
				queued += p.position_kind + 2;
			end
			if ($urandom_range(0, 19) == 0) begin
				hold_input = 1;
				while (in_valid || row_queue.size() > 0)
					@(posedge clk);
				hold_input = 0;
			end
			while (point_queue.size() > 4)
				@(posedge clk);
		end
		wait_drained();
		repeat (800) @(posedge clk);

		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

`default_nettype wire
